/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on nothing; the user module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while in reset.
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ffa_pkg.sv */
// Package for the first-fit heap allocator: widths, codes, header type.
// No dependencies.
package ffa_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 8;
  localparam int UNIT_W     = 12;   // unit address / size width
  localparam int NU_W       = 14;   // request size in units incl. header
  localparam int STEP_W     = 13;   // list walk counter
  localparam int BYTE_W     = 16;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_DONATE = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_MEM   = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO_REQ = 2'd3;

  // One header unit: next link and size in units
  typedef struct packed {
    logic [UNIT_W-1:0] link;
    logic [UNIT_W-1:0] size;
  } header_t;

endpackage

/* src/ffa_in_if.sv */
// Request channel of the allocator: valid/ready plus request word.
// Depends on ffa_pkg.
interface ffa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::OP_W-1:0]      operation;
  logic [ffa_pkg::BYTE_W-1:0]    byte_count;
  logic [ffa_pkg::UNIT_W-1:0]    block_unit;
  logic [ffa_pkg::UNIT_W-1:0]    region_units;

  modport source (output valid, operation, byte_count, block_unit, region_units,
                  input ready);
  modport sink   (input valid, operation, byte_count, block_unit, region_units,
                  output ready);
endinterface

/* src/ffa_out_if.sv */
// Response channel of the allocator: valid/ready plus result word.
// Depends on ffa_pkg.
interface ffa_out_if;
  logic                        valid;
  logic                        ready;
  logic [ffa_pkg::ST_W-1:0]    status;
  logic [ffa_pkg::UNIT_W-1:0]  granted_unit;
  logic [ffa_pkg::UNIT_W-1:0]  free_units;

  modport source (output valid, status, granted_unit, free_units, input ready);
  modport sink   (input valid, status, granted_unit, free_units, output ready);
endinterface

/* src/first_fit_heap_allocator_core.sv */
// First-fit free-list allocator with coalescing, header memory and sequencer.
// Depends on ffa_pkg, ffa_in_if, ffa_out_if and assert_macros.svh.
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------
//  req     | in  | operation, byte_count, block_unit, region_units
//  rsp     | out | status, granted_unit, free_units
//
// One request at a time; req.ready is low from accept until the response word is taken.
// Allocate: examines one free block per step (next header read overlaps the compare)
// and then marks the header of the granted block before the response.
// Free/donate: free first audits the block header; each list step loads a header, then
// compares; an optional merge read and two header writes follow; rejects end sooner.
// Reset clears control, sentinel link and free total; header memory stays undefined.
`include "assert_macros.svh"

module first_fit_heap_allocator_core (
  input  logic       clk,
  input  logic       rst,
  ffa_in_if.sink     req,
  ffa_out_if.source  rsp
);

  localparam int UW = ffa_pkg::UNIT_W;
  localparam logic [UW:0] HEAP_LIM = (UW+1)'(ffa_pkg::HEAP_UNITS);
  localparam logic [ffa_pkg::STEP_W-1:0] ALLOC_STEPS =
    ffa_pkg::STEP_W'(ffa_pkg::HEAP_UNITS + 1);
  localparam logic [ffa_pkg::STEP_W-1:0] INS_STEPS =
    ffa_pkg::STEP_W'(ffa_pkg::HEAP_UNITS);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_A_EVAL = 10'b0000000010,
    S_A_MARK = 10'b0000000100,
    S_F_CHK  = 10'b0000001000,
    S_I_LOAD = 10'b0000010000,
    S_I_EVAL = 10'b0000100000,
    S_I_NXT  = 10'b0001000000,
    S_I_WRP  = 10'b0010000000,
    S_I_WRQ  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;

  // Working registers
  logic [UW-1:0]                p, q, s, qlink, qs, plink, psz;
  logic [ffa_pkg::NU_W-1:0]     nu;
  logic [ffa_pkg::STEP_W-1:0]   steps;
  logic [ffa_pkg::ST_W-1:0]     status_r;
  logic [UW-1:0]                granted_r, free_total, sentinel;

  // Header memory, one read and one write port
  ffa_pkg::header_t mem [ffa_pkg::HEAP_UNITS];
  ffa_pkg::header_t hdr, wr_hdr;
  logic [UW-1:0]    rd_addr, wr_addr;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_hdr;
    hdr <= mem[rd_addr];
  end

  // Request decode
  logic                       accept;
  logic [ffa_pkg::BYTE_W:0]   nb_round;
  logic [ffa_pkg::NU_W-1:0]   nu_req;
  logic [UW:0]                donate_end;
  logic [UW-1:0]              free_hdr;
  assign accept     = req.valid && req.ready;
  assign nb_round   = {1'b0, req.byte_count} + (ffa_pkg::BYTE_W+1)'(ffa_pkg::UNIT_BYTES - 1);
  assign nu_req     = ffa_pkg::NU_W'(nb_round / ffa_pkg::UNIT_BYTES) + 1'b1;
  assign donate_end = {1'b0, req.block_unit} + {1'b0, req.region_units};
  assign free_hdr   = req.block_unit - 1'b1;

  // Allocate step
  logic                       fit, whole, a_stop;
  logic [ffa_pkg::STEP_W-1:0] steps_inc;
  assign fit       = {2'b00, hdr.size} >= nu;
  assign whole     = {2'b00, hdr.size} <= nu + 1'b1;
  assign steps_inc = steps + 1'b1;
  assign a_stop    = (steps_inc > ALLOC_STEPS) || (hdr.link == '0);

  // Insert step
  logic          brk, bad, merge_n, merge_q, i_stop, chk_ok;
  logic [UW:0]   p_end, q_end, h_end;
  assign p_end   = {1'b0, p} + {1'b0, s};
  assign q_end   = {1'b0, q} + {1'b0, qs};
  assign h_end   = {1'b0, p} + {1'b0, hdr.size};
  assign brk     = (p > q && p < qlink) || (q >= qlink && (p > q || p < qlink));
  assign bad     = (q < p && q_end > {1'b0, p}) || (qlink > p && p_end > {1'b0, qlink});
  assign merge_n = (qlink != '0) && (p_end == {1'b0, qlink});
  assign merge_q = (q != '0) && (q_end == {1'b0, p});
  assign i_stop  = steps_inc > INS_STEPS;
  assign chk_ok  = (hdr.link == p) && (hdr.size >= UW'(2)) && (h_end <= HEAP_LIM);

  // Memory port control
  always_comb begin
    rd_addr = qlink;
    wr_en   = 1'b0;
    wr_addr = p;
    wr_hdr  = '{link: plink, size: psz};
    unique case (state)
      S_IDLE:   rd_addr = (req.operation == ffa_pkg::OP_FREE) ? free_hdr : sentinel;
      S_A_EVAL: begin
        rd_addr = hdr.link;
        if (fit) begin
          wr_en = 1'b1;
          if (whole) begin
            wr_addr = q;
            wr_hdr  = '{link: hdr.link, size: qs};
          end else begin
            wr_hdr  = '{link: hdr.link, size: hdr.size - UW'(nu)};
          end
        end
      end
      S_A_MARK: begin
        wr_en  = 1'b1;
        wr_hdr = '{link: p, size: psz};
      end
      S_I_WRP:  wr_en = 1'b1;
      S_I_WRQ: begin
        wr_en   = 1'b1;
        wr_addr = q;
        wr_hdr  = merge_q ? '{link: plink, size: qs + psz} : '{link: p, size: qs};
      end
      S_F_CHK, S_I_LOAD, S_I_EVAL, S_I_NXT, S_DONE: ;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sentinel   <= '0;
      free_total <= '0;
      status_r   <= ffa_pkg::ST_OK;
      granted_r  <= '0;
    end else begin
      if (wr_en && wr_addr == '0) sentinel <= wr_hdr.link;
      unique case (state)
        S_IDLE: if (accept) begin
          granted_r <= '0;
          q         <= '0;
          qs        <= '0;
          qlink     <= sentinel;
          steps     <= '0;
          nu        <= nu_req;
          unique case (req.operation)
            ffa_pkg::OP_ALLOC: begin
              p <= sentinel;
              if (req.byte_count == '0) begin
                status_r <= ffa_pkg::ST_ZERO_REQ;
                state    <= S_DONE;
              end else if (sentinel == '0) begin
                status_r <= ffa_pkg::ST_NO_MEM;
                state    <= S_DONE;
              end else begin
                state <= S_A_EVAL;
              end
            end
            ffa_pkg::OP_FREE: begin
              p <= free_hdr;
              if (req.block_unit >= UW'(2)) begin
                state <= S_F_CHK;
              end else begin
                status_r <= ffa_pkg::ST_BAD_FREE;
                state    <= S_DONE;
              end
            end
            ffa_pkg::OP_DONATE: begin
              p <= req.block_unit;
              s <= req.region_units;
              if (req.block_unit != '0 && req.region_units >= UW'(2) &&
                  donate_end <= HEAP_LIM) begin
                state <= S_I_EVAL;
              end else begin
                status_r <= ffa_pkg::ST_BAD_FREE;
                state    <= S_DONE;
              end
            end
            default: begin
              status_r <= ffa_pkg::ST_OK;
              state    <= S_DONE;
            end
          endcase
        end
        // First-fit check of block p; step to its successor, or stop at list end or step limit
        S_A_EVAL: begin
          if (fit) begin
            if (whole) begin
              psz <= hdr.size;
            end else begin
              p   <= p + (hdr.size - UW'(nu));
              psz <= UW'(nu);
            end
            state <= S_A_MARK;
          end else if (a_stop) begin
            status_r <= ffa_pkg::ST_NO_MEM;
            state    <= S_DONE;
          end else begin
            steps <= steps_inc;
            q     <= p;
            qs    <= hdr.size;
            p     <= hdr.link;
          end
        end
        S_A_MARK: begin
          free_total <= free_total - psz;
          granted_r  <= p + 1'b1;
          status_r   <= ffa_pkg::ST_OK;
          state      <= S_DONE;
        end
        // Audit the header of a freed block
        S_F_CHK: begin
          s <= hdr.size;
          if (chk_ok) begin
            state <= S_I_EVAL;
          end else begin
            status_r <= ffa_pkg::ST_BAD_FREE;
            state    <= S_DONE;
          end
        end
        S_I_LOAD: begin
          qlink <= (q == '0) ? sentinel : hdr.link;
          qs    <= (q == '0) ? '0 : hdr.size;
          state <= S_I_EVAL;
        end
        // Find the address-ordered slot, then check overlap
        S_I_EVAL: begin
          plink <= qlink;
          psz   <= s;
          if (brk) begin
            if (bad) begin
              status_r <= ffa_pkg::ST_BAD_FREE;
              state    <= S_DONE;
            end else if (merge_n) begin
              state <= S_I_NXT;
            end else begin
              state <= S_I_WRP;
            end
          end else if (i_stop) begin
            status_r <= ffa_pkg::ST_BAD_FREE;
            state    <= S_DONE;
          end else begin
            steps <= steps_inc;
            q     <= qlink;
            state <= S_I_LOAD;
          end
        end
        S_I_NXT: begin
          plink <= hdr.link;
          psz   <= s + hdr.size;
          state <= S_I_WRP;
        end
        S_I_WRP: state <= S_I_WRQ;
        S_I_WRQ: begin
          free_total <= free_total + s;
          status_r   <= ffa_pkg::ST_OK;
          state      <= S_DONE;
        end
        S_DONE: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Handshake and response word
  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = (state == S_DONE);
  assign rsp.status       = status_r;
  assign rsp.granted_unit = granted_r;
  assign rsp.free_units   = free_total;

  // Assertion terms
  logic rsp_take, rsp_fail, zero_acc;
  assign rsp_take = rsp.valid && rsp.ready;
  assign rsp_fail = rsp.valid && (rsp.status != ffa_pkg::ST_OK);
  assign zero_acc = accept && (req.operation == ffa_pkg::OP_ALLOC) && (req.byte_count == '0);

  `FFA_ASSERT_ALWAYS(a_one_side, rst || !(req.ready && rsp.valid), "ready while response pending")
  `FFA_ASSERT(a_grant_ok, rsp_fail |-> (rsp.granted_unit == '0), "grant on failed request")
  `FFA_ASSERT(a_back_idle, rsp_take |=> req.ready, "no return to idle after response")
  `FFA_ASSERT(a_zero_req, zero_acc |=> (rsp_fail && rsp.status == ffa_pkg::ST_ZERO_REQ), "zero request not answered")

endmodule
